// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the coordinate hash block.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== src/chl_pkg.sv =====
// Package of the coordinate hash lookup block: sizes, beat types, sequencer
// state and the control and status bundles. No dependencies.
package chl_pkg;

	localparam int NUM_BUCKETS = 512;
	localparam int POOL_DEPTH  = 4096;
	localparam int COORD_BITS  = 16;

	localparam int BKT_W   = $clog2(NUM_BUCKETS);
	localparam int SIZE_W  = $clog2(NUM_BUCKETS + 1);
	localparam int IDX_W   = $clog2(POOL_DEPTH);
	localparam int NODE_W  = $clog2(POOL_DEPTH + 1);
	localparam int TSIZE_W = 10;

	localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(512);
	// golden ratio fraction (sqrt5-1)/2 in 0.32 fixed point
	localparam logic [31:0] HASH_FRAC_A = 32'd2654435769;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic                  command;
		logic [COORD_BITS-1:0] coord_x;
		logic [COORD_BITS-1:0] coord_y;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_number;
		logic              created;
		logic              pool_full;
	} rsp_t;

	// one pool entry: point and link to the next node number (0 ends the chain)
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [NODE_W-1:0]     next;
	} ent_t;

	// one bucket word: chain head pool index and its valid flag
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] head;
	} bkt_t;

	typedef enum logic [1:0] {
		MUL_SS,  // s * (s + 1)
		MUL_KA,  // key * A
		MUL_SF   // size * frac
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_CLR,
		ST_MUL1,
		ST_KEY,
		ST_MUL2,
		ST_MUL3,
		ST_BRD,
		ST_BCHK,
		ST_ECHK,
		ST_INS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic    req_ready;
		logic    sweep_wr;
		logic    cnt_clr;
		logic    mul_en;
		mul_op_t mul_op;
		logic    key_ld;
		logic    bkt_rd;
		logic    hd_ld;
		logic    ent_rd_head;
		logic    ent_rd_next;
		logic    hit_ld;
		logic    ins;
		logic    res_ld;
	} ctl_t;

	typedef struct packed {
		logic req_valid;
		logic req_cmd;
		logic sweep_last;
		logic bkt_valid;
		logic ent_match;
		logic ent_last;
		logic out_free;
	} sts_t;

endpackage

// ===== src/chl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the bucket heads and the node pool.
module chl_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/chl_mul.sv =====
// Shared 32x32 multiplier of the hash path with its operand selection.
// Depends on chl_pkg for the operation codes and widths.
module chl_mul (
	input  logic                        clk,
	input  logic                        en,
	input  chl_pkg::mul_op_t            op,
	input  logic [chl_pkg::COORD_BITS:0] sum,
	input  logic [31:0]                 key,
	input  logic [chl_pkg::SIZE_W-1:0]  size,
	output logic [63:0]                 prod
);

	logic [31:0] opa;
	logic [31:0] opb;
	logic [63:0] prod_q;

	// pick the operands of this step
	always_comb begin
		case (op)
			chl_pkg::MUL_SS: begin
				opa = 32'(sum);
				opb = 32'(sum) + 32'd1;
			end
			chl_pkg::MUL_KA: begin
				opa = key;
				opb = chl_pkg::HASH_FRAC_A;
			end
			chl_pkg::MUL_SF: begin
				opa = 32'(size);
				opb = prod_q[31:0];
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// register the product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {32'd0, opa} * {32'd0, opb};
		end
	end

	assign prod = prod_q;

endmodule

// ===== src/chl_ctrl.sv =====
// Sequencer of the coordinate hash block: steps the shared multiplier,
// the bucket and pool reads and the clearing sweep. Depends on chl_pkg.
module chl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  chl_pkg::sts_t sts,
	output chl_pkg::ctl_t ctl
);

	chl_pkg::state_t state_q;
	chl_pkg::state_t state_d;

	// state register; reset starts with a sweep of the bucket store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chl_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			chl_pkg::ST_SWEEP: begin
				if (sts.sweep_last) state_d = chl_pkg::ST_IDLE;
			end
			chl_pkg::ST_IDLE: begin
				if (sts.req_valid) begin
					if (sts.req_cmd == chl_pkg::CMD_CLEAR) state_d = chl_pkg::ST_CLR;
					else state_d = chl_pkg::ST_MUL1;
				end
			end
			chl_pkg::ST_CLR: begin
				if (sts.sweep_last) state_d = chl_pkg::ST_DONE;
			end
			chl_pkg::ST_MUL1: state_d = chl_pkg::ST_KEY;
			chl_pkg::ST_KEY:  state_d = chl_pkg::ST_MUL2;
			chl_pkg::ST_MUL2: state_d = chl_pkg::ST_MUL3;
			chl_pkg::ST_MUL3: state_d = chl_pkg::ST_BRD;
			chl_pkg::ST_BRD:  state_d = chl_pkg::ST_BCHK;
			chl_pkg::ST_BCHK: begin
				if (sts.bkt_valid) state_d = chl_pkg::ST_ECHK;
				else state_d = chl_pkg::ST_INS;
			end
			chl_pkg::ST_ECHK: begin
				if (sts.ent_match) state_d = chl_pkg::ST_DONE;
				else if (sts.ent_last) state_d = chl_pkg::ST_INS;
			end
			chl_pkg::ST_INS: state_d = chl_pkg::ST_DONE;
			chl_pkg::ST_DONE: begin
				if (sts.out_free) state_d = chl_pkg::ST_IDLE;
			end
			default: state_d = chl_pkg::ST_SWEEP;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			chl_pkg::ST_SWEEP: ctl.sweep_wr = 1'b1;
			chl_pkg::ST_IDLE: begin
				ctl.req_ready = 1'b1;
				ctl.cnt_clr   = sts.req_valid && (sts.req_cmd == chl_pkg::CMD_CLEAR);
			end
			chl_pkg::ST_CLR: ctl.sweep_wr = 1'b1;
			chl_pkg::ST_MUL1: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = chl_pkg::MUL_SS;
			end
			chl_pkg::ST_KEY: ctl.key_ld = 1'b1;
			chl_pkg::ST_MUL2: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = chl_pkg::MUL_KA;
			end
			chl_pkg::ST_MUL3: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = chl_pkg::MUL_SF;
			end
			chl_pkg::ST_BRD: ctl.bkt_rd = 1'b1;
			chl_pkg::ST_BCHK: begin
				ctl.hd_ld       = 1'b1;
				ctl.ent_rd_head = sts.bkt_valid;
			end
			chl_pkg::ST_ECHK: begin
				ctl.hit_ld      = sts.ent_match;
				ctl.ent_rd_next = !sts.ent_match && !sts.ent_last;
			end
			chl_pkg::ST_INS: ctl.ins = 1'b1;
			chl_pkg::ST_DONE: ctl.res_ld = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

// ===== src/coord_hash_lookup_or_insert.sv =====
// Top level of the coordinate hash block: ports, configuration, datapath and
// the bucket and pool RAMs. Depends on chl_pkg, chl_ram, chl_mul, chl_ctrl.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  req     | req_valid / req_stall  | req_t: command, coord_x, coord_y
//  rsp     | rsp_valid / rsp_stall  | rsp_t: node_number, created, pool_full
//  cfg     | cfg_wen                | cfg_wdata: table_size
//
// A lookup steps through MUL1, KEY, MUL2, MUL3, BRD and BCHK, one ECHK per chain node
// visited, INS on a miss and DONE; the shared multiplier runs three passes and the
// pool RAM is read once per node. A clear beat sweeps the buckets, one bucket a cycle.
// After reset a clearing pass over all NUM_BUCKETS buckets runs with req_stall high.
// A new beat is taken while a finished result waits in the output register;
// the block holds in its last step only when that register is still full.
`include "assert_macros.svh"

module coord_hash_lookup_or_insert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  chl_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output chl_pkg::rsp_t                 rsp,
	input  logic                          cfg_wen,
	input  logic [chl_pkg::TSIZE_W-1:0]   cfg_wdata
);

	chl_pkg::ctl_t ctl;
	chl_pkg::sts_t sts;

	logic [chl_pkg::TSIZE_W-1:0]    tsize_q;
	logic [chl_pkg::SIZE_W-1:0]     size_eff;
	logic [chl_pkg::COORD_BITS-1:0] x_q;
	logic [chl_pkg::COORD_BITS-1:0] y_q;
	logic [chl_pkg::COORD_BITS:0]   sum;
	logic [31:0]                    key_q;
	logic [63:0]                    prod;
	logic [chl_pkg::BKT_W-1:0]      bkt_q;
	logic [chl_pkg::BKT_W-1:0]      sweep_q;
	logic                           bvalid_q;
	logic [chl_pkg::IDX_W-1:0]      bhead_q;
	logic [chl_pkg::IDX_W-1:0]      idx_q;
	logic [chl_pkg::NODE_W-1:0]     cnt_q;
	logic                           full;
	logic                           req_fire;
	chl_pkg::rsp_t                  res_q;
	chl_pkg::rsp_t                  rsp_q;
	logic                           rsp_valid_q;

	chl_pkg::bkt_t                  bkt_rdata;
	chl_pkg::bkt_t                  bkt_wdata;
	logic                           bkt_we;
	logic [chl_pkg::BKT_W-1:0]      bkt_waddr;
	chl_pkg::ent_t                  ent_rdata;
	chl_pkg::ent_t                  ent_wdata;
	logic                           ent_we;
	logic                           ent_re;
	logic [chl_pkg::IDX_W-1:0]      ent_raddr;

	assign req_fire  = req_valid && ctl.req_ready;
	assign req_stall = !ctl.req_ready;
	assign full      = 32'(cnt_q) >= chl_pkg::POOL_DEPTH;

	// status to the sequencer; it only looks at valid while ready
	always_comb begin
		sts.req_valid  = req_valid;
		sts.req_cmd    = req.command;
		sts.sweep_last = 32'(sweep_q) == chl_pkg::NUM_BUCKETS - 1;
		sts.bkt_valid  = bkt_rdata.valid;
		sts.ent_match  = (ent_rdata.x == x_q) && (ent_rdata.y == y_q);
		sts.ent_last   = ent_rdata.next == '0;
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	chl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= chl_pkg::TSIZE_RESET;
		end else if (cfg_wen) begin
			tsize_q <= cfg_wdata;
		end
	end

	// clamp the size to 1..NUM_BUCKETS
	always_comb begin
		if (tsize_q == '0) begin
			size_eff = chl_pkg::SIZE_W'(1);
		end else if (32'(tsize_q) > chl_pkg::NUM_BUCKETS) begin
			size_eff = chl_pkg::SIZE_W'(chl_pkg::NUM_BUCKETS);
		end else begin
			size_eff = chl_pkg::SIZE_W'(tsize_q);
		end
	end

	assign sum = {1'b0, x_q} + {1'b0, y_q};

	chl_mul u_mul (
		.clk  (clk),
		.en   (ctl.mul_en),
		.op   (ctl.mul_op),
		.sum  (sum),
		.key  (key_q),
		.size (size_eff),
		.prod (prod)
	);

	// hold the point and the intermediate hash values
	always_ff @(posedge clk) begin
		if (req_fire) begin
			x_q <= req.coord_x;
			y_q <= req.coord_y;
		end
		// low 32 bits of the Cantor key are all the hash needs
		if (ctl.key_ld) begin
			key_q <= 32'(y_q) + prod[32:1];
		end
		if (ctl.bkt_rd) begin
			bkt_q <= prod[32 +: chl_pkg::BKT_W];
		end
		if (ctl.hd_ld) begin
			bvalid_q <= bkt_rdata.valid;
			bhead_q  <= bkt_rdata.head;
		end
		if (ctl.ent_rd_head) begin
			idx_q <= bkt_rdata.head;
		end else if (ctl.ent_rd_next) begin
			idx_q <= chl_pkg::IDX_W'(ent_rdata.next - chl_pkg::NODE_W'(1));
		end
	end

	// sweep pointer for clearing the buckets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctl.sweep_wr) begin
			if (sts.sweep_last) sweep_q <= '0;
			else sweep_q <= sweep_q + chl_pkg::BKT_W'(1);
		end
	end

	// node count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.cnt_clr) begin
			cnt_q <= '0;
		end else if (ctl.ins && !full) begin
			cnt_q <= cnt_q + chl_pkg::NODE_W'(1);
		end
	end

	// bucket store: sweep writes empty words, insert writes the new head
	always_comb begin
		bkt_we    = ctl.sweep_wr || (ctl.ins && !full);
		bkt_waddr = ctl.sweep_wr ? sweep_q : bkt_q;
		bkt_wdata = '0;
		if (!ctl.sweep_wr) begin
			bkt_wdata.valid = 1'b1;
			bkt_wdata.head  = chl_pkg::IDX_W'(cnt_q);
		end
	end

	chl_ram #(
		.DEPTH (chl_pkg::NUM_BUCKETS),
		.WIDTH (chl_pkg::IDX_W + 1)
	) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.re    (ctl.bkt_rd),
		.raddr (prod[32 +: chl_pkg::BKT_W]),
		.rdata (bkt_rdata)
	);

	// pool store: new node links to the old chain head
	always_comb begin
		ent_we      = ctl.ins && !full;
		ent_wdata.x = x_q;
		ent_wdata.y = y_q;
		if (bvalid_q) ent_wdata.next = {1'b0, bhead_q} + chl_pkg::NODE_W'(1);
		else ent_wdata.next = '0;
		ent_re = ctl.ent_rd_head || ctl.ent_rd_next;
		if (ctl.ent_rd_head) begin
			ent_raddr = bkt_rdata.head;
		end else begin
			ent_raddr = chl_pkg::IDX_W'(ent_rdata.next - chl_pkg::NODE_W'(1));
		end
	end

	chl_ram #(
		.DEPTH (chl_pkg::POOL_DEPTH),
		.WIDTH (2 * chl_pkg::COORD_BITS + chl_pkg::NODE_W)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (chl_pkg::IDX_W'(cnt_q)),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// build the result of the current beat
	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_q <= '0;
		end else if (ctl.hit_ld) begin
			res_q.node_number <= {1'b0, idx_q} + chl_pkg::NODE_W'(1);
		end else if (ctl.ins) begin
			if (full) begin
				res_q.pool_full <= 1'b1;
			end else begin
				res_q.node_number <= cnt_q + chl_pkg::NODE_W'(1);
				res_q.created     <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.res_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_ld) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_CLK(a_cnt_bound, 32'(cnt_q) <= chl_pkg::POOL_DEPTH, "node count beyond pool depth")
	`ASSERT_CLK(a_rsp_flags, rsp_valid |-> !(rsp.created && rsp.pool_full), "created with pool full")
	`ASSERT_CLK(a_full_node, rsp_valid && rsp.pool_full |-> rsp.node_number == '0, "node on full pool")
	`ASSERT_CLK(a_load_free, ctl.res_ld |-> !rsp_valid_q || !rsp_stall, "result over a held beat")
	`ASSERT_NEXT(a_clr_cnt, ctl.cnt_clr, cnt_q == '0, "count not cleared")

endmodule

// ===== tb/coord_hash_lookup_or_insert_tb.sv =====
// Testbench of coord_hash_lookup_or_insert: sends point and clear beats and table size
// writes, and checks every result beat against its own model of the chained hash table.
// Depends on chl_pkg and the RTL of coord_hash_lookup_or_insert.
module coord_hash_lookup_or_insert_tb;

	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam logic [63:0] GOLDEN_FRAC = 64'd2654435769;
	localparam int unsigned SETTLE_CYCLES = 20;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_stall;
	chl_pkg::req_t                 req = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	chl_pkg::rsp_t                 rsp;
	logic                          cfg_wen = 1'b0;
	logic [chl_pkg::TSIZE_W-1:0]   cfg_wdata = '0;

	// model of the table: bucket heads, pool entries, node count, bucket count
	logic [chl_pkg::IDX_W-1:0]      chain_head [chl_pkg::NUM_BUCKETS];
	bit                             chain_live [chl_pkg::NUM_BUCKETS];
	logic [chl_pkg::COORD_BITS-1:0] slot_x [chl_pkg::POOL_DEPTH];
	logic [chl_pkg::COORD_BITS-1:0] slot_y [chl_pkg::POOL_DEPTH];
	logic [chl_pkg::NODE_W-1:0]     slot_link [chl_pkg::POOL_DEPTH];
	int unsigned                    nodes_used = 0;
	logic [chl_pkg::TSIZE_W-1:0]    bucket_count = chl_pkg::TSIZE_W'(512);

	chl_pkg::rsp_t awaited_nodes [$];
	int unsigned   mismatches = 0;
	int unsigned   results_seen = 0;
	int unsigned   cycle_count = 0;
	bit            idle_on = 1'b0;
	int unsigned   stall_left = 0;

	coord_hash_lookup_or_insert u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// multiplicative hash of the Cantor pairing, scaled to the buckets in use
	function automatic logic [chl_pkg::BKT_W-1:0] bucket_index(
			input logic [chl_pkg::COORD_BITS-1:0] x,
			input logic [chl_pkg::COORD_BITS-1:0] y);
		logic [63:0] sum, key, frac, span, slot;
		sum = 64'(x) + 64'(y);
		key = 64'(y) + (sum * (sum + 64'd1)) / 64'd2;
		frac = (key * GOLDEN_FRAC) & 64'hFFFF_FFFF;
		span = 64'(bucket_count);
		if (span == 64'd0)
			span = 64'd1;
		if (span > 64'(chl_pkg::NUM_BUCKETS))
			span = 64'(chl_pkg::NUM_BUCKETS);
		slot = (span * frac) >> 32;
		if (slot >= 64'(chl_pkg::NUM_BUCKETS))
			slot = 64'(chl_pkg::NUM_BUCKETS - 1);
		return slot[chl_pkg::BKT_W-1:0];
	endfunction

	// find or create the node of one beat and advance the table model
	function automatic chl_pkg::rsp_t resolve_point(input chl_pkg::req_t beat);
		chl_pkg::rsp_t             res;
		logic [chl_pkg::BKT_W-1:0] slot;
		logic [chl_pkg::IDX_W-1:0] idx;
		res = '0;
		if (beat.command == chl_pkg::CMD_CLEAR) begin
			foreach (chain_live[i])
				chain_live[i] = 1'b0;
			nodes_used = 0;
			return res;
		end
		slot = bucket_index(beat.coord_x, beat.coord_y);
		if (chain_live[slot]) begin
			idx = chain_head[slot];
			// links are node numbers 1..POOL_DEPTH, so idx stays in range
			for (int steps = 0; steps < chl_pkg::POOL_DEPTH; steps++) begin
				if (slot_x[idx] == beat.coord_x && slot_y[idx] == beat.coord_y) begin
					res.node_number = {1'b0, idx} + chl_pkg::NODE_W'(1);
					return res;
				end
				if (slot_link[idx] == '0)
					break;
				idx = chl_pkg::IDX_W'(slot_link[idx] - chl_pkg::NODE_W'(1));
			end
		end
		if (nodes_used >= chl_pkg::POOL_DEPTH) begin
			res.pool_full = 1'b1;
			return res;
		end
		// push the new entry at the chain head
		slot_x[chl_pkg::IDX_W'(nodes_used)] = beat.coord_x;
		slot_y[chl_pkg::IDX_W'(nodes_used)] = beat.coord_y;
		slot_link[chl_pkg::IDX_W'(nodes_used)] = chain_live[slot] ?
			{1'b0, chain_head[slot]} + chl_pkg::NODE_W'(1) : '0;
		chain_head[slot] = chl_pkg::IDX_W'(nodes_used);
		chain_live[slot] = 1'b1;
		nodes_used++;
		res.node_number = chl_pkg::NODE_W'(nodes_used);
		res.created = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got %0d, expected %0d",
			results_seen, what, got, want);
		mismatches++;
	endtask

	// check result beats, then predict from request beats and register writes
	always @(posedge clk) begin
		chl_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_nodes.size() == 0) begin
					report_mismatch("result with none awaited", 32'(rsp.node_number), '0);
				end else begin
					want = awaited_nodes.pop_front();
					if (rsp.node_number !== want.node_number)
						report_mismatch("node_number", 32'(rsp.node_number),
							32'(want.node_number));
					if (rsp.created !== want.created)
						report_mismatch("created", 32'(rsp.created), 32'(want.created));
					if (rsp.pool_full !== want.pool_full)
						report_mismatch("pool_full", 32'(rsp.pool_full), 32'(want.pool_full));
				end
				results_seen++;
			end
			if (req_valid && !req_stall)
				awaited_nodes.push_back(resolve_point(req));
			if (cfg_wen)
				bucket_count = cfg_wdata;
		end
	end

	// stall the result channel in random bursts, only while idle_on is set
	always @(posedge clk) begin
		if (!idle_on) begin
			stall_left <= 0;
			rsp_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// drop the run when it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("coord_hash_lookup_or_insert test failed");
			$finish;
		end
	end

	// hold one request beat until the block takes it, sometimes after a random gap
	task automatic send_beat(input chl_pkg::req_t beat);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic lookup_point(input logic [chl_pkg::COORD_BITS-1:0] x,
			input logic [chl_pkg::COORD_BITS-1:0] y);
		chl_pkg::req_t beat;
		beat.command = chl_pkg::CMD_LOOKUP;
		beat.coord_x = x;
		beat.coord_y = y;
		send_beat(beat);
	endtask

	task automatic clear_table();
		chl_pkg::req_t beat;
		beat.command = chl_pkg::CMD_CLEAR;
		beat.coord_x = chl_pkg::COORD_BITS'($urandom);
		beat.coord_y = chl_pkg::COORD_BITS'($urandom);
		send_beat(beat);
	endtask

	// stop sending and wait until every awaited result has come back
	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_nodes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_table_size(input logic [chl_pkg::TSIZE_W-1:0] value);
		wait_quiet();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// first and repeated points, coordinate extremes, clear and renumbering
	task automatic test_directed_points();
		lookup_point('0, '0);
		lookup_point('0, '0);
		lookup_point('1, '1);
		lookup_point('1, '0);
		lookup_point('0, '1);
		lookup_point(16'hAAAA, 16'h5555);
		lookup_point(16'h5555, 16'hAAAA);
		lookup_point('1, '1);
		lookup_point(16'h5555, 16'hAAAA);
		clear_table();
		lookup_point('0, '0);
		lookup_point(16'd1, '0);
		lookup_point('0, 16'd1);
	endtask

	// zero and oversized bucket counts, one bucket, resize without rehash
	task automatic test_table_sizes();
		set_table_size('0);
		clear_table();
		lookup_point(16'd1, 16'd2);
		lookup_point(16'd3, 16'd4);
		lookup_point(16'd5, 16'd6);
		lookup_point(16'd1, 16'd2);
		lookup_point(16'd5, 16'd6);
		set_table_size('1);
		lookup_point(16'd7, 16'd8);
		lookup_point(16'd7, 16'd8);
		lookup_point(16'd3, 16'd4);
		set_table_size(chl_pkg::TSIZE_W'(1));
		lookup_point(16'd3, 16'd4);
		set_table_size(chl_pkg::TSIZE_W'(3));
		lookup_point(16'd7, 16'd8);
		lookup_point(16'd1, 16'd2);
		set_table_size(chl_pkg::TSIZE_W'(512));
	endtask

	// rounds of mostly repeated points with fresh ones, clears and table size changes among them
	task automatic test_random_traffic(input int beats, input bit idling);
		logic [chl_pkg::COORD_BITS-1:0] seen_x [32];
		logic [chl_pkg::COORD_BITS-1:0] seen_y [32];
		logic [chl_pkg::TSIZE_W-1:0]    size_pick;
		int                             sent, pick;
		int unsigned                    roll;
		idle_on = idling;
		foreach (seen_x[i]) begin
			seen_x[i] = chl_pkg::COORD_BITS'($urandom);
			seen_y[i] = chl_pkg::COORD_BITS'($urandom);
		end
		sent = 0;
		size_pick = chl_pkg::TSIZE_W'(512);
		while (sent < beats) begin
			roll = $urandom_range(0, 9);
			if (roll < 2) begin
				size_pick = chl_pkg::TSIZE_W'($urandom);
				set_table_size(size_pick);
			end else if (roll < 5) begin
				size_pick = chl_pkg::TSIZE_W'($urandom_range(1, 16));
				set_table_size(size_pick);
			end else if (roll == 5) begin
				case ($urandom_range(0, 5))
					0: size_pick = chl_pkg::TSIZE_W'(0);
					1: size_pick = chl_pkg::TSIZE_W'(1);
					2: size_pick = chl_pkg::TSIZE_W'(511);
					3: size_pick = chl_pkg::TSIZE_W'(512);
					4: size_pick = chl_pkg::TSIZE_W'(513);
					default: size_pick = '1;
				endcase
				set_table_size(size_pick);
			end
			// keep chains short when few buckets are in use
			if (size_pick < 8 || $urandom_range(0, 1) == 0) begin
				clear_table();
				sent++;
			end
			repeat ($urandom_range(20, 60)) begin
				roll = $urandom_range(0, 99);
				pick = $urandom_range(0, 31);
				if (roll < 4) begin
					clear_table();
				end else if (roll < 60) begin
					lookup_point(seen_x[pick], seen_y[pick]);
				end else begin
					if (roll < 80) begin
						seen_x[pick] = chl_pkg::COORD_BITS'($urandom);
						seen_y[pick] = chl_pkg::COORD_BITS'($urandom);
					end else begin
						seen_x[pick] = chl_pkg::COORD_BITS'($urandom_range(0, 15));
						seen_y[pick] = chl_pkg::COORD_BITS'($urandom_range(0, 15));
					end
					lookup_point(seen_x[pick], seen_y[pick]);
				end
				sent++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// let the clearing pass after reset finish
		while (req_stall)
			@(posedge clk);
		idle_on = 1'b1;
		test_directed_points();
		test_table_sizes();
		test_random_traffic(450, 1'b1);
		test_random_traffic(120, 1'b0);
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("coord_hash_lookup_or_insert test passed");
		else
			$display("coord_hash_lookup_or_insert test failed");
		$finish;
	end

endmodule
